/* hw/rtl/fpcm_pkg.sv */
// Package for the floating-point constant multiplier.
// Exception codes, register indexes and configuration widths. No dependencies.
package fpcm_pkg;
	typedef enum logic [1:0] {
		EXC_ZERO   = 2'd0,
		EXC_NORMAL = 2'd1,
		EXC_INF    = 2'd2,
		EXC_NAN    = 2'd3
	} exc_t;

	localparam int unsigned CFG_IDX_BITS = 3;
	localparam int unsigned ADDEND_BITS  = 11;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CONST_ZERO = 3'd0,
		REG_CONST_NEG  = 3'd1,
		REG_CONST_SIG  = 3'd2,
		REG_CUT_FRAC   = 3'd3,
		REG_EXP_ADDEND = 3'd4
	} cfg_idx_t;
endpackage

/* hw/rtl/fpcm_if.sv */
// Valid/ready channel carrying one floating-point number.
// Depends on fpcm_pkg for the exception code type.
interface fpcm_if #(
	parameter int EXP_BITS  = 8,
	parameter int FRAC_BITS = 23
);
	logic                 valid;
	logic                 ready;
	fpcm_pkg::exc_t       exception;
	logic                 sign;
	logic [EXP_BITS-1:0]  exponent;
	logic [FRAC_BITS-1:0] fraction;

	modport source (output valid, exception, sign, exponent, fraction, input ready);
	modport sink   (input valid, exception, sign, exponent, fraction, output ready);
endinterface

/* hw/rtl/fp_constant_multiplier.sv */
// Top level of the floating-point constant multiplier.
// Depends on fpcm_pkg and fpcm_if.
//
//  channel    | dir | payload
//  in_ch      | in  | exception, sign, exponent, fraction
//  out_ch     | out | exception, sign, exponent, fraction
//  cfg_*      | in  | write enable, index, data
//
// Input register, then product and rounding into the result register.
// One request per cycle unless stalled; the multiplier path sets the clock.
// Stalls hold both stages; the input stage still fills while the result waits.
// Reset clears valid bits and configuration to constant 1.0.
module fp_constant_multiplier #(
	parameter int IN_EXP_BITS   = 8,
	parameter int IN_FRAC_BITS  = 23,
	parameter int OUT_EXP_BITS  = 8,
	parameter int OUT_FRAC_BITS = 23,
	parameter int CONST_BITS    = 26
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fpcm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [CONST_BITS-1:0]               cfg_data,
	fpcm_if.sink                                in_ch,
	fpcm_if.source                              out_ch
);
	import fpcm_pkg::*;

	localparam int RSIZE   = IN_FRAC_BITS + 1 + CONST_BITS;
	localparam int WIN     = OUT_FRAC_BITS + 1;
	localparam int LOW_GT  = RSIZE - OUT_FRAC_BITS - 2;
	localparam int LOW_LE  = RSIZE - OUT_FRAC_BITS - 3;
	localparam int PAD     = (LOW_LE < 0) ? -LOW_LE : 0;
	localparam int PW      = RSIZE + PAD;
	localparam int SUM_W   = ((IN_EXP_BITS > ADDEND_BITS) ? IN_EXP_BITS : ADDEND_BITS)
		+ ((OUT_EXP_BITS > 11) ? OUT_EXP_BITS - 9 : 3);

	// configuration
	logic                          czero_q, cneg_q;
	logic [CONST_BITS-1:0]         csig_q;
	logic [IN_FRAC_BITS-1:0]       cut_q;
	logic signed [ADDEND_BITS-1:0] addend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			czero_q  <= 1'b0;
			cneg_q   <= 1'b0;
			csig_q   <= CONST_BITS'(1) << (CONST_BITS - 1);
			cut_q    <= '1;
			addend_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CONST_ZERO: czero_q  <= cfg_data[0];
				REG_CONST_NEG:  cneg_q   <= cfg_data[0];
				REG_CONST_SIG:  csig_q   <= cfg_data;
				REG_CUT_FRAC:   cut_q    <= IN_FRAC_BITS'(cfg_data);
				REG_EXP_ADDEND: addend_q <= ADDEND_BITS'(cfg_data);
				default: ;
			endcase
		end
	end

	// stage 1: input register
	logic                    v_s1;
	exc_t                    exc_s1;
	logic                    sgn_s1;
	logic [IN_EXP_BITS-1:0]  exp_s1;
	logic [IN_FRAC_BITS-1:0] frac_s1;
	logic                    v_s2;
	logic                    adv_s1, adv_s2;

	assign adv_s2      = !v_s2 || out_ch.ready;
	assign adv_s1      = !v_s1 || adv_s2;
	assign in_ch.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv_s1) v_s1 <= in_ch.valid;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_ch.valid) begin
			exc_s1  <= in_ch.exception;
			sgn_s1  <= in_ch.sign;
			exp_s1  <= in_ch.exponent;
			frac_s1 <= in_ch.fraction;
		end
	end

	// product, window, rounding, exponent
	logic [RSIZE-1:0]  prod;
	logic [PW-1:0]     prod_p;
	logic              gt;
	logic [WIN-1:0]    win;
	logic [WIN:0]      rnd;
	logic signed [SUM_W-1:0] sum;
	logic              under, over;
	exc_t              rexc;

	assign prod   = RSIZE'({1'b1, frac_s1}) * RSIZE'(csig_q);
	assign prod_p = {prod, {PAD{1'b0}}};
	assign gt     = frac_s1 > cut_q;
	assign win    = gt ? WIN'(prod_p >> (LOW_GT + PAD)) : WIN'(prod_p >> (LOW_LE + PAD));
	assign rnd    = {1'b0, win} + (WIN+1)'(1);
	assign sum    = SUM_W'(signed'({1'b0, exp_s1})) + SUM_W'(addend_q)
		+ SUM_W'({1'b0, gt}) + SUM_W'({1'b0, rnd[WIN]});
	assign under  = sum < 0;
	assign over   = sum >= (SUM_W'(1) <<< OUT_EXP_BITS);

	always_comb begin
		if (czero_q)
			rexc = (exc_s1 == EXC_ZERO || exc_s1 == EXC_NORMAL) ? EXC_ZERO : EXC_NAN;
		else if (exc_s1 == EXC_ZERO || (exc_s1 == EXC_NORMAL && under))
			rexc = EXC_ZERO;
		else if (exc_s1 == EXC_INF || (exc_s1 == EXC_NORMAL && over))
			rexc = EXC_INF;
		else if (exc_s1 == EXC_NAN)
			rexc = EXC_NAN;
		else
			rexc = EXC_NORMAL;
	end

	// stage 2: result register
	exc_t                     exc_s2;
	logic                     sgn_s2;
	logic [OUT_EXP_BITS-1:0]  exp_s2;
	logic [OUT_FRAC_BITS-1:0] frac_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv_s2) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			exc_s2  <= rexc;
			sgn_s2  <= sgn_s1 ^ cneg_q;
			exp_s2  <= (rexc == EXC_NORMAL) ? OUT_EXP_BITS'(sum) : '0;
			frac_s2 <= (rexc == EXC_NORMAL) ? rnd[OUT_FRAC_BITS:1] : '0;
		end
	end

	assign out_ch.valid     = v_s2;
	assign out_ch.exception = exc_s2;
	assign out_ch.sign      = sgn_s2;
	assign out_ch.exponent  = exp_s2;
	assign out_ch.fraction  = frac_s2;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_ch.ready |=> v_s2 && $stable(exp_s2) && $stable(frac_s2))
		else $error("result changed while stalled");
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && exc_s2 != EXC_NORMAL |-> exp_s2 == '0 && frac_s2 == '0)
		else $error("non-normal result with nonzero fields");
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !v_s2 |=> v_s2)
		else $error("stage 1 item not advanced");
endmodule

/* test/fpcm_checker.sv */
// Checker for the floating-point constant multiplier: mirrors the configuration
// writes, predicts each result and compares it. Depends on fpcm_pkg and fpcm_if.
`timescale 1ns / 100ps
module fpcm_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [fpcm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [25:0]                         cfg_data,
	fpcm_if.sink                                in_ch,
	fpcm_if.sink                                out_ch,
	output int                                  errors,
	output int                                  pending
);
	import fpcm_pkg::*;

	typedef struct packed {
		exc_t        exc;
		logic        sgn;
		logic [7:0]  expo;
		logic [22:0] frac;
	} fpnum_t;

	logic        k_zero, k_neg;
	logic [25:0] k_sig;
	logic [22:0] k_cut;
	logic signed [10:0] k_add;
	fpnum_t      products[$];

	function automatic fpnum_t scale(fpnum_t x);
		fpnum_t r;
		logic [49:0] prod;
		logic [23:0] win;
		logic [24:0] rnd;
		logic gt;
		int sum;
		r.sgn = x.sgn ^ k_neg;
		r.expo = '0;
		r.frac = '0;
		if (k_zero) begin
			r.exc = (x.exc == EXC_ZERO || x.exc == EXC_NORMAL) ? EXC_ZERO : EXC_NAN;
			return r;
		end
		gt = x.frac > k_cut;
		prod = {1'b1, x.frac} * k_sig;
		// window of 24 bits: low bit at 25 when shifted, 24 otherwise
		win = gt ? prod[48:25] : prod[47:24];
		rnd = {1'b0, win} + 25'd1;
		sum = int'(x.expo) + int'(k_add) + int'(gt) + int'(rnd[24]);
		if (x.exc == EXC_ZERO || (x.exc == EXC_NORMAL && sum < 0)) r.exc = EXC_ZERO;
		else if (x.exc == EXC_INF || (x.exc == EXC_NORMAL && sum >= 256)) r.exc = EXC_INF;
		else if (x.exc == EXC_NAN) r.exc = EXC_NAN;
		else begin
			r.exc = EXC_NORMAL;
			r.expo = sum[7:0];
			r.frac = rnd[23:1];
		end
		return r;
	endfunction

	assign pending = products.size();

	always @(posedge clk or negedge arst_n) begin
		fpnum_t x, got, want;
		if (!arst_n) begin
			k_zero <= 1'b0;
			k_neg <= 1'b0;
			k_sig <= 26'h2000000;
			k_cut <= '1;
			k_add <= '0;
			errors <= 0;
			products.delete();
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				x = {in_ch.exception, in_ch.sign, in_ch.exponent, in_ch.fraction};
				products = {products, scale(x)};
			end
			if (out_ch.valid && out_ch.ready) begin
				got = {out_ch.exception, out_ch.sign, out_ch.exponent, out_ch.fraction};
				if (products.size() == 0) begin
					$error("result with no request outstanding");
					errors <= errors + 1;
				end else begin
					want = products.pop_front();
					if (got.exc !== want.exc) $error("exception exp %0d got %0d", want.exc, got.exc);
					if (got.sgn !== want.sgn) $error("sign exp %0d got %0d", want.sgn, got.sgn);
					if (got.expo !== want.expo) $error("exponent exp %0d got %0d", want.expo, got.expo);
					if (got.frac !== want.frac) $error("fraction exp %h got %h", want.frac, got.frac);
					if (got !== want) errors <= errors + 1;
				end
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					REG_CONST_ZERO: k_zero <= cfg_data[0];
					REG_CONST_NEG:  k_neg <= cfg_data[0];
					REG_CONST_SIG:  k_sig <= cfg_data;
					REG_CUT_FRAC:   k_cut <= cfg_data[22:0];
					REG_EXP_ADDEND: k_add <= cfg_data[10:0];
					default: ;
				endcase
			end
		end
	end
endmodule

/* test/fp_constant_multiplier_tb.sv */
// Testbench top for the floating-point constant multiplier: clock, reset,
// configuration phases and request stimulus. Depends on fpcm_pkg, fpcm_if, fpcm_checker.
`timescale 1ns / 100ps
module fp_constant_multiplier_tb;
	import fpcm_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [25:0] cfg_data = '0;
	int errors, pending;
	int send_idle = 0, recv_stall = 0;
	bit hold_off = 0;

	fpcm_if in_ch ();
	fpcm_if out_ch ();

	always #2 clk = ~clk;

	fp_constant_multiplier u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	fpcm_checker u_chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.sink),
		.errors(errors), .pending(pending)
	);

	initial begin
		in_ch.valid = 1'b0;
		in_ch.exception = EXC_ZERO;
		in_ch.sign = 1'b0;
		in_ch.exponent = '0;
		in_ch.fraction = '0;
		out_ch.ready = 1'b0;
	end

	always @(posedge clk) begin
		if (hold_off) out_ch.ready <= 1'b0;
		else out_ch.ready <= ($urandom_range(99) >= recv_stall);
	end

	task automatic write_reg(cfg_idx_t idx, logic [25:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// valid stays up after an accept; the next request or a drain decides
	task automatic send(exc_t e, logic s, logic [7:0] ex, logic [22:0] fr);
		while ($urandom_range(99) < send_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.exception <= e;
		in_ch.sign <= s;
		in_ch.exponent <= ex;
		in_ch.fraction <= fr;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic setup(logic z, logic n, logic [25:0] sig, logic [22:0] cut,
			logic [10:0] add);
		write_reg(REG_CONST_ZERO, 26'(z));
		write_reg(REG_CONST_NEG, 26'(n));
		write_reg(REG_CONST_SIG, sig);
		write_reg(REG_CUT_FRAC, 26'(cut));
		write_reg(REG_EXP_ADDEND, 26'(add));
		cfg_we <= 1'b0;
	endtask

	task automatic send_random();
		logic [7:0] ex;
		logic [22:0] fr;
		ex = (($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(90, 165)));
		fr = 23'($urandom);
		if ($urandom_range(9) == 0) fr = ($urandom_range(1)) ? '1 : '0;
		send(($urandom_range(4) == 0) ? exc_t'($urandom_range(3)) : EXC_NORMAL,
			1'($urandom), ex, fr);
	endtask

	initial begin
		logic [25:0] sig;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: reset constant, then extremes
		send(EXC_ZERO, 1'b0, 8'd0, 23'd0);
		send(EXC_NORMAL, 1'b1, 8'd255, '1);
		send(EXC_NORMAL, 1'b0, 8'd0, 23'd0);
		send(EXC_INF, 1'b1, 8'd3, 23'd5);
		send(EXC_NAN, 1'b0, 8'd200, 23'd7);
		drain();
		setup(1'b0, 1'b1, '1, 23'h400000, 11'h3ff);
		send(EXC_NORMAL, 1'b0, 8'd0, '1);
		send(EXC_NORMAL, 1'b1, 8'd1, 23'h3fffff);
		send(EXC_NORMAL, 1'b0, 8'd255, 23'd0);
		send(EXC_NAN, 1'b1, 8'd0, 23'd0);
		drain();
		setup(1'b0, 1'b0, 26'h2000000, 23'd0, 11'h400);
		send(EXC_NORMAL, 1'b0, 8'd255, 23'd1);
		send(EXC_NORMAL, 1'b1, 8'd255, 23'd0);
		send(EXC_NORMAL, 1'b0, 8'd100, '1);
		send(EXC_INF, 1'b0, 8'd100, 23'd0);
		drain();
		setup(1'b1, 1'b1, '1, '1, 11'd0);
		send(EXC_ZERO, 1'b0, 8'd9, 23'd9);
		send(EXC_NORMAL, 1'b0, 8'd9, 23'd9);
		send(EXC_INF, 1'b1, 8'd9, 23'd9);
		send(EXC_NAN, 1'b0, 8'd9, 23'd9);
		drain();
		setup(1'b0, 1'b0, 26'h1234567, 23'h1000, 11'h7ff);
		send(EXC_NORMAL, 1'b0, 8'd0, 23'h800);
		send(EXC_NORMAL, 1'b1, 8'd128, 23'h2000);
		drain();
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 88; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 88; end
				default: begin send_idle = 16; recv_stall = 16; end
			endcase
			sig = {1'b1, 25'($urandom)};
			setup($urandom_range(9) == 0, 1'($urandom), sig,
				($urandom_range(1)) ? 23'($urandom) : 23'(((64'h1000000000000 / sig) << 0) & 0),
				11'($urandom_range(2047)));
			if (ph == 5) begin
				fork
					begin
						hold_off = 1;
						repeat (300) @(posedge clk);
						hold_off = 0;
					end
					repeat (20) send_random();
				join
			end
			for (int i = 0; i < 135; i++) send_random();
			drain();
		end
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
